FILE: hw/rtl/sia_pkg.sv
// sia_pkg: shared types and constants for the stack integer alu
// operation and status codes, serial unit control, request and response payloads
// no dependencies

package sia_pkg;

   localparam int STACK_DEPTH_DEFAULT = 16;
   localparam int WORD_WIDTH_DEFAULT  = 32;

   localparam int OP_BITS     = 4;
   localparam int DEPTH_BITS  = 5;
   localparam int STATUS_BITS = 2;

   localparam logic [OP_BITS-1:0] OP_PUSH = 4'd0;
   localparam logic [OP_BITS-1:0] OP_ADD  = 4'd1;
   localparam logic [OP_BITS-1:0] OP_SUB  = 4'd2;
   localparam logic [OP_BITS-1:0] OP_MUL  = 4'd3;
   localparam logic [OP_BITS-1:0] OP_DIV  = 4'd4;
   localparam logic [OP_BITS-1:0] OP_MOD  = 4'd5;
   localparam logic [OP_BITS-1:0] OP_AND  = 4'd6;
   localparam logic [OP_BITS-1:0] OP_OR   = 4'd7;
   localparam logic [OP_BITS-1:0] OP_NOT  = 4'd8;
   localparam logic [OP_BITS-1:0] OP_NE   = 4'd9;
   localparam logic [OP_BITS-1:0] OP_LE   = 4'd10;
   localparam logic [OP_BITS-1:0] OP_GE   = 4'd11;
   localparam logic [OP_BITS-1:0] OP_LT   = 4'd12;
   localparam logic [OP_BITS-1:0] OP_GT   = 4'd13;
   localparam logic [OP_BITS-1:0] OP_EQ   = 4'd14;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_UNDER = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_OVER  = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_DIVZ  = 2'd3;

   localparam logic [1:0] KIND_MUL = 2'd0;
   localparam logic [1:0] KIND_DIV = 2'd1;
   localparam logic [1:0] KIND_MOD = 2'd2;

   typedef struct packed {
      logic [OP_BITS-1:0] operation;
      logic signed [31:0] push_value;
   } sia_req_type;

   typedef struct packed {
      logic signed [31:0]     top_value;
      logic [STATUS_BITS-1:0] status;
      logic [DEPTH_BITS-1:0]  stack_depth;
   } sia_rsp_type;

   typedef struct packed {
      logic       start;
      logic [1:0] kind;
   } sia_unit_ctl_type;

endpackage

FILE: hw/rtl/sia_serial_unit.sv
// sia_serial_unit: one bit per cycle multiplier and signed divider
// shift/add for mul, restoring shift/subtract on magnitudes for div and mod
// depends on sia_pkg

module sia_serial_unit #(
   parameter int WORD_WIDTH = sia_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sia_pkg::sia_unit_ctl_type ctl,
   input  logic [WORD_WIDTH-1:0]     left,
   input  logic [WORD_WIDTH-1:0]     right,
   output logic                      done,
   output logic [WORD_WIDTH-1:0]     result
);
   import sia_pkg::*;

   localparam int CNT_W = $clog2(WORD_WIDTH + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [1:0]            kind_ff, kind_in;
   logic                  neg_ff, neg_in;
   logic [WORD_WIDTH-1:0] acc_ff, acc_in;
   logic [WORD_WIDTH-1:0] a_ff, a_in;
   logic [WORD_WIDTH-1:0] b_ff, b_in;
   logic [WORD_WIDTH-1:0] result_ff, result_in;
   logic [WORD_WIDTH-1:0] trial;
   logic [WORD_WIDTH-1:0] mag_left;
   logic [WORD_WIDTH-1:0] mag_right;
   logic [WORD_WIDTH-1:0] fix_value;

   assign trial     = {acc_ff[WORD_WIDTH-2:0], a_ff[WORD_WIDTH-1]};
   assign mag_left  = left[WORD_WIDTH-1] ? (WORD_WIDTH'(0) - left) : left;
   assign mag_right = right[WORD_WIDTH-1] ? (WORD_WIDTH'(0) - right) : right;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      kind_in   = kind_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      result_in = result_ff;
      fix_value = (kind_ff == KIND_DIV) ? a_ff : acc_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         kind_in = ctl.kind;
         acc_in  = '0;
         if (ctl.kind == KIND_MUL) begin
            a_in   = left;
            b_in   = right;
            neg_in = 1'b0;
         end else begin
            a_in   = mag_left;
            b_in   = mag_right;
            neg_in = (ctl.kind == KIND_DIV) ? (left[WORD_WIDTH-1] ^ right[WORD_WIDTH-1])
                                            : left[WORD_WIDTH-1];
         end
      end else if (busy_ff) begin
         if (cnt_ff == CNT_W'(WORD_WIDTH)) begin
            busy_in   = 1'b0;
            done_in   = 1'b1;
            result_in = neg_ff ? (WORD_WIDTH'(0) - fix_value) : fix_value;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (kind_ff == KIND_MUL) begin
               if (b_ff[0]) begin
                  acc_in = acc_ff + a_ff;
               end
               a_in = {a_ff[WORD_WIDTH-2:0], 1'b0};
               b_in = {1'b0, b_ff[WORD_WIDTH-1:1]};
            end else if (trial >= b_ff) begin
               acc_in = trial - b_ff;
               a_in   = {a_ff[WORD_WIDTH-2:0], 1'b1};
            end else begin
               acc_in = trial;
               a_in   = {a_ff[WORD_WIDTH-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      kind_ff   <= kind_in;
      neg_ff    <= neg_in;
      acc_ff    <= acc_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

FILE: hw/rtl/stack_integer_alu.sv
// stack_integer_alu: operand stack in a synchronous memory with the top word cached
// push, add, sub, logic and compare ops pass from request transfer through S_READ and
// S_RESP to the registered response; mul, div and mod with valid operands also wait in
// S_WAIT for the one bit per cycle serial unit; one item in flight, next request taken
// once the response is registered, so a stalled response also holds off new requests
// synchronous reset empties the stack; memory is not cleared; depends on sia_pkg

module stack_integer_alu #(
   parameter int STACK_DEPTH = sia_pkg::STACK_DEPTH_DEFAULT,
   parameter int WORD_WIDTH  = sia_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sia_pkg::sia_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sia_pkg::sia_rsp_type rsp_data
);
   import sia_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   logic [WORD_WIDTH-1:0] stack_mem [STACK_DEPTH];

   logic [1:0]             state_ff, state_in;
   logic [OP_BITS-1:0]     op_ff, op_in;
   logic signed [31:0]     pv_ff, pv_in;
   logic [WORD_WIDTH-1:0]  top_ff, top_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic [WORD_WIDTH-1:0]  rd_ff;
   sia_rsp_type            rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   req_xfer;
   logic                   mem_we;
   logic [AW-1:0]          rd_addr;
   logic [AW-1:0]          wr_addr;
   logic [CW-1:0]          count_m1;
   logic [CW-1:0]          count_m2;
   logic [63:0]            pv_wide;
   logic [63:0]            top_wide;
   logic [WORD_WIDTH-1:0]  alu_res;
   logic                   l_nz, r_nz, l_lt_r, r_lt_l;
   sia_unit_ctl_type       unit_ctl;
   logic                   unit_done;
   logic [WORD_WIDTH-1:0]  unit_result;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign count_m1  = count_ff - CW'(1);
   assign count_m2  = count_ff - CW'(2);
   assign rd_addr   = count_m2[AW-1:0];
   assign wr_addr   = count_m1[AW-1:0];
   assign pv_wide   = 64'(pv_ff);
   assign top_wide  = 64'(top_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[wr_addr] <= top_ff;
      end
      if (req_xfer) begin
         rd_ff <= stack_mem[rd_addr];
      end
   end

   // left operand from memory, right operand is the cached top
   assign l_nz   = (rd_ff != '0);
   assign r_nz   = (top_ff != '0);
   assign l_lt_r = ($signed(rd_ff) < $signed(top_ff));
   assign r_lt_l = ($signed(top_ff) < $signed(rd_ff));

   always_comb begin
      alu_res = '0;
      case (op_ff)
         OP_ADD:  alu_res = rd_ff + top_ff;
         OP_SUB:  alu_res = rd_ff - top_ff;
         OP_AND:  alu_res = WORD_WIDTH'(l_nz && r_nz);
         OP_OR:   alu_res = WORD_WIDTH'(l_nz || r_nz);
         OP_NE:   alu_res = WORD_WIDTH'(rd_ff != top_ff);
         OP_LE:   alu_res = WORD_WIDTH'(!r_lt_l);
         OP_GE:   alu_res = WORD_WIDTH'(!l_lt_r);
         OP_LT:   alu_res = WORD_WIDTH'(l_lt_r);
         OP_GT:   alu_res = WORD_WIDTH'(r_lt_l);
         OP_EQ:   alu_res = WORD_WIDTH'(rd_ff == top_ff);
         default: alu_res = '0;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      pv_in          = pv_ff;
      top_in         = top_ff;
      count_in       = count_ff;
      status_in      = status_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      mem_we         = 1'b0;
      unit_ctl.start = 1'b0;
      unit_ctl.kind  = KIND_MUL;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               op_in    = req_data.operation;
               pv_in    = req_data.push_value;
               state_in = S_READ;
            end
         end
         S_READ: begin
            status_in = STATUS_OK;
            state_in  = S_RESP;
            case (op_ff)
               OP_PUSH: begin
                  if (count_ff == CW'(STACK_DEPTH)) begin
                     status_in = STATUS_OVER;
                  end else begin
                     mem_we   = (count_ff != '0);
                     top_in   = WORD_WIDTH'(pv_wide);
                     count_in = count_ff + CW'(1);
                  end
               end
               OP_NOT: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_UNDER;
                  end else begin
                     top_in = WORD_WIDTH'(!r_nz);
                  end
               end
               OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR,
               OP_NE, OP_LE, OP_GE, OP_LT, OP_GT, OP_EQ: begin
                  if (count_ff < CW'(2)) begin
                     status_in = STATUS_UNDER;
                  end else if ((op_ff == OP_DIV || op_ff == OP_MOD) && !r_nz) begin
                     status_in = STATUS_DIVZ;
                  end else if (op_ff == OP_MUL || op_ff == OP_DIV || op_ff == OP_MOD) begin
                     unit_ctl.start = 1'b1;
                     unit_ctl.kind  = (op_ff == OP_MUL) ? KIND_MUL :
                                      (op_ff == OP_DIV) ? KIND_DIV : KIND_MOD;
                     state_in       = S_WAIT;
                  end else begin
                     top_in   = alu_res;
                     count_in = count_m1;
                  end
               end
               default: begin
                  status_in = STATUS_OK;
               end
            endcase
         end
         S_WAIT: begin
            if (unit_done) begin
               top_in   = unit_result;
               count_in = count_m1;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.top_value   = (count_ff != '0) ? top_wide[31:0] : '0;
               rsp_in.status      = status_ff;
               rsp_in.stack_depth = DEPTH_BITS'(count_ff);
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff     <= op_in;
      pv_ff     <= pv_in;
      top_ff    <= top_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   sia_serial_unit #(
      .WORD_WIDTH(WORD_WIDTH)
   ) u_serial (
      .clock (clock),
      .reset (reset),
      .ctl   (unit_ctl),
      .left  (rd_ff),
      .right (top_ff),
      .done  (unit_done),
      .result(unit_result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hw/rtl/sia_checker.sv
// sia_checker: port level checks for stack_integer_alu
// bound to the top level below; depends on sia_pkg

module sia_checker #(
   parameter int STACK_DEPTH = sia_pkg::STACK_DEPTH_DEFAULT
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input sia_pkg::sia_rsp_type rsp_data
);
   import sia_pkg::*;

   localparam logic SMALL_STACK = (STACK_DEPTH < 32);
   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = DEPTH_BITS'(STACK_DEPTH);

   // a stalled response transfer holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && SMALL_STACK |-> rsp_data.stack_depth <= DEPTH_MAX)
      else $error("stack depth beyond capacity");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && SMALL_STACK && rsp_data.status == STATUS_OVER
      |-> rsp_data.stack_depth == DEPTH_MAX)
      else $error("overflow reported on a stack that is not full");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && SMALL_STACK && rsp_data.status == STATUS_DIVZ
      |-> rsp_data.stack_depth >= DEPTH_BITS'(2))
      else $error("divide by zero reported without two operands");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && SMALL_STACK && rsp_data.stack_depth == '0 |-> rsp_data.top_value == '0)
      else $error("empty stack with nonzero top");

endmodule

bind stack_integer_alu sia_checker #(
   .STACK_DEPTH(STACK_DEPTH)
) u_sia_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);
